// File: src/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk_s, rst_n_s, prop) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error("assertion failed");
// cond must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, clk_s, rst_n_s, cond) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk_s, rst_n_s, prop)
`define ASSERT_NEVER(label, clk_s, rst_n_s, cond)
`endif
`endif

// File: src/brbs_pkg.sv
// Shared constants, command codes and inter-module structs for the byte ring buffer.
// No dependencies.
package brbs_pkg;

	localparam int DEPTH  = 8192;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int FILL_W = 14;
	localparam int STAT_W = 32;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// request from the pointer logic to the byte store
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// everything of a result except the popped byte
	typedef struct packed {
		logic              read_valid;
		logic              push_stored;
		logic [FILL_W-1:0] fill_level;
		logic [STAT_W-1:0] accepted_total;
		logic [STAT_W-1:0] overflow_total;
	} res_meta_t;

endpackage

// File: src/brbs_store.sv
// Byte store: DEPTH x 8 synchronous RAM, one write and one registered read port.
// Depends on brbs_pkg.
module brbs_store (
	input  logic              clk,
	input  brbs_pkg::mem_req_t req,
	output logic [7:0]        rdata
);
	import brbs_pkg::*;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/brbs_ctrl.sv
// Pointer, fill and statistics logic: decodes one command per accepted item.
// Depends on brbs_pkg; drives brbs_store.
module brbs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [1:0]         cmd,
	input  logic [7:0]         push_byte,
	input  logic               output_enable,
	output brbs_pkg::mem_req_t req,
	output brbs_pkg::res_meta_t meta
);
	import brbs_pkg::*;

	logic [IDX_W-1:0]  wr_q, rd_q, wr_d, rd_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [STAT_W-1:0] acc_q, ovf_q, acc_d, ovf_d;
	logic              full, empty;
	logic [IDX_W-1:0]  wr_next, rd_next;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign wr_next = (wr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
	assign rd_next = (rd_q == IDX_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;

	always_comb begin
		wr_d  = wr_q;
		rd_d  = rd_q;
		cnt_d = cnt_q;
		acc_d = acc_q;
		ovf_d = ovf_q;
		req.we    = 1'b0;
		req.waddr = wr_q;
		req.wdata = push_byte;
		req.re    = 1'b0;
		req.raddr = rd_q;
		meta.read_valid  = 1'b0;
		meta.push_stored = 1'b0;
		unique case (cmd)
			CMD_PUSH: begin
				if (output_enable) begin
					if (!full) begin
						req.we           = en;
						wr_d             = wr_next;
						cnt_d            = cnt_q + 1'b1;
						acc_d            = acc_q + 1'b1;
						meta.push_stored = 1'b1;
					end else begin
						ovf_d = ovf_q + 1'b1;
					end
				end
			end
			CMD_POP: begin
				if (!empty) begin
					req.re          = en;
					rd_d            = rd_next;
					cnt_d           = cnt_q - 1'b1;
					meta.read_valid = 1'b1;
				end
			end
			CMD_CLEAR: begin
				wr_d  = '0;
				rd_d  = '0;
				cnt_d = '0;
			end
			default: begin
			end
		endcase
		meta.fill_level     = FILL_W'(cnt_d);
		meta.accepted_total = acc_d;
		meta.overflow_total = ovf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
			acc_q <= '0;
			ovf_q <= '0;
		end else if (en) begin
			wr_q  <= wr_d;
			rd_q  <= rd_d;
			cnt_q <= cnt_d;
			acc_q <= acc_d;
			ovf_q <= ovf_d;
		end
	end

endmodule

// File: src/byte_ring_buffer_with_stats_unit.sv
// Top level of the byte ring buffer with statistics.
// Depends on brbs_pkg, brbs_ctrl, brbs_store and assert_macros.svh.
//
// Byte FIFO held in a DEPTH-entry (8192) single-port-write, registered-read RAM.
// Each input item carries a command in s_tuser (push, pop, clear) and a byte in
// s_tdata; each gives exactly one result item with the popped byte, its valid
// flag, the push-stored flag, the fill level after the command and the two
// wrapping 32-bit statistics counters (stored pushes, pushes lost to a full
// store). Pushes are dropped with no effect while output_enable is 0; clear
// empties the queue but keeps the counters. Rate: one item per cycle sustained
// while m_tready is high; a stalled output holds off new items. A result passes
// through the RAM's registered read in stage 1, then the output register.
// Pointers and counters update at acceptance, so a pop right behind a push reads
// the RAM after the write and needs no bypass. The store needs no clearing pass:
// the fill count guards every read, so the block takes items straight out of
// reset. output_enable is written via the cfg channel, always ready, and is
// meant to change only while the block is idle.
module byte_ring_buffer_with_stats_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: output_enable
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] push_byte
	input  logic [1:0]  s_tuser,  // [1:0] cmd
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // [7:0] read_byte, [21:8] fill_level,
	                              // [53:22] accepted_total, [85:54] overflow_total
	output logic [1:0]  m_tuser   // [0] read_valid, [1] push_stored
);
	import brbs_pkg::*;

	`include "assert_macros.svh"

	logic       oe_q;
	logic       accept;
	logic       valid_s1;
	res_meta_t  meta_s1;
	logic       s1_adv;
	logic       out_valid_q;
	res_meta_t  out_meta_q;
	logic [7:0] out_byte_q;
	mem_req_t   req;
	res_meta_t  meta;
	logic [7:0] rdata;

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oe_q <= 1'b0;
		end else if (cfg_valid) begin
			oe_q <= cfg_data;
		end
	end

	// stage 1 waits on the RAM read; it moves on when the output slot frees
	assign s1_adv   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;
	assign accept   = s_tvalid && s_tready;

	brbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (accept),
		.cmd          (s_tuser),
		.push_byte    (s_tdata),
		.output_enable(oe_q),
		.req          (req),
		.meta         (meta)
	);

	brbs_store u_store (
		.clk  (clk),
		.req  (req),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// output register; RAM data is stable while stage 1 stalls (no read issued)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_meta_q <= meta_s1;
			out_byte_q <= meta_s1.read_valid ? rdata : 8'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_meta_q.overflow_total, out_meta_q.accepted_total,
	                   out_meta_q.fill_level, out_byte_q};
	assign m_tuser  = {out_meta_q.push_stored, out_meta_q.read_valid};

	// a pop result never also reports a stored push
	`ASSERT_NEVER(a_pop_and_push, clk, arst_n, valid_s1 && meta_s1.read_valid && meta_s1.push_stored)
	// fill level never goes beyond the store depth
	`ASSERT_CLK(a_fill_bound, clk, arst_n, !valid_s1 || (meta_s1.fill_level <= FILL_W'(DEPTH)))
	// a stalled stage 1 keeps its result for the next cycle
	`ASSERT_CLK(a_s1_hold, clk, arst_n, (valid_s1 && !s1_adv) |=> (valid_s1 && $stable(meta_s1)))
	// an accepted item always lands in stage 1
	`ASSERT_CLK(a_accept_s1, clk, arst_n, accept |=> valid_s1)

endmodule
